// ===== rtl/nibble_bank_switch_with_irq_timer_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the bank-switch controller
// Property wrappers that compile away when NO_ASSERTIONS is defined.
// ---------------------------------------------------------------------------
`ifndef NIBBLE_BANK_SWITCH_WITH_IRQ_TIMER_ASSERT_SVH
`define NIBBLE_BANK_SWITCH_WITH_IRQ_TIMER_ASSERT_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define NBS_ASSERT_IMPL(label, clock, rst_n, ante, cons) \
	label: assert property (@(posedge clock) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("nbs assertion failed");

// next-cycle implication
`define NBS_ASSERT_NEXT(label, clock, rst_n, ante, cons) \
	label: assert property (@(posedge clock) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("nbs assertion failed");

`else

`define NBS_ASSERT_IMPL(label, clock, rst_n, ante, cons)
`define NBS_ASSERT_NEXT(label, clock, rst_n, ante, cons)

`endif

`endif

// ===== rtl/nbsirq_pkg.sv =====
// ---------------------------------------------------------------------------
// nbsirq_pkg
// Shared constants for the bank-switch controller with scanline IRQ timer.
// ---------------------------------------------------------------------------
`default_nettype none

package nbsirq_pkg;

	localparam int unsigned LINE_CYCLES_DEF = 113;

	localparam int unsigned SLOT_COUNT = 11;
	localparam int unsigned CFG_DATA_W = 9;

	// configuration register indexes
	localparam logic CFG_PRG_BANK_COUNT = 1'b0;
	localparam logic CFG_PATCH_MODE     = 1'b1;

	localparam logic [8:0] PRG_COUNT_RESET = 9'd16;
	localparam logic [15:0] PATCH_RELOAD   = 16'd114;

	// item kinds
	localparam logic KIND_WRITE = 1'b0;
	localparam logic KIND_TICK  = 1'b1;

	// address pages of the slot registers
	localparam logic [3:0] PAGE_PRG01 = 4'h8;
	localparam logic [3:0] PAGE_PRG2  = 4'h9;
	localparam logic [3:0] PAGE_CHR_A = 4'hA;
	localparam logic [3:0] PAGE_CHR_B = 4'hB;
	localparam logic [3:0] PAGE_CHR_C = 4'hC;
	localparam logic [3:0] PAGE_CHR_D = 4'hD;

	localparam logic [3:0] SLOT_PRG2     = 4'd2;
	localparam logic [3:0] SLOT_CHR_BASE = 4'd3;

	// control register addresses
	localparam logic [15:0] ADDR_RELOAD0 = 16'hE000;
	localparam logic [15:0] ADDR_RELOAD1 = 16'hE001;
	localparam logic [15:0] ADDR_RELOAD2 = 16'hE002;
	localparam logic [15:0] ADDR_RELOAD3 = 16'hE003;
	localparam logic [15:0] ADDR_LOAD    = 16'hF000;
	localparam logic [15:0] ADDR_ENABLE  = 16'hF001;
	localparam logic [15:0] ADDR_MIRROR  = 16'hF002;

	// mirroring codes
	localparam logic [1:0] MIRROR_HORIZ  = 2'd0;
	localparam logic [1:0] MIRROR_VERT   = 2'd1;
	localparam logic [1:0] MIRROR_SINGLE = 2'd2;

endpackage

`default_nettype wire

// ===== rtl/nibble_bank_switch_with_irq_timer.sv =====
// ---------------------------------------------------------------------------
// nibble_bank_switch_with_irq_timer
// Cartridge bank-switch controller: nibble-wide bank slot writes, mirroring
// select and a scanline IRQ down-counter.
// ---------------------------------------------------------------------------
// Takes one item per clock, either a CPU register write or a scanline tick,
// and returns exactly one result per item. An accepted item sits in the input
// register, where the slot decode, nibble merge and the counter
// subtract-and-compare run; the result register is loaded from it when the
// result side has room, so items stream at one per cycle while the result
// side keeps taking them. A stalled result holds the input register, and ready
// then drops once that register is full. Writes to the prg_bank_count and
// patch_mode registers through the cfg port are to be made only while no item
// is in flight; the block itself does not enforce this. Writing prg_bank_count
// also reloads the 9000 slot (slot 2) with the count minus two.
`default_nettype none

module nibble_bank_switch_with_irq_timer #(
	parameter int unsigned LINE_CYCLES = nbsirq_pkg::LINE_CYCLES_DEF
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,

	input  wire logic                               cfg_we,
	input  wire logic                               cfg_index,
	input  wire logic [nbsirq_pkg::CFG_DATA_W-1:0]  cfg_data,

	input  wire logic                               item_valid,
	output logic                                    item_ready,
	input  wire logic                               kind,
	input  wire logic [15:0]                        address,
	input  wire logic [7:0]                         value,

	output logic                                    result_valid,
	input  wire logic                               result_ready,
	output logic                                    slot_changed,
	output logic [3:0]                              slot_index,
	output logic [7:0]                              slot_bank,
	output logic [7:0]                              fixed_bank,
	output logic [1:0]                              mirroring,
	output logic                                    irq_request
);
	import nbsirq_pkg::*;

	localparam logic [15:0] LINE_STEP = 16'(LINE_CYCLES);

	// configuration
	logic [8:0] prg_count_q;
	logic       patch_q;

	// mapper state
	logic [7:0]  bank_q [SLOT_COUNT];
	logic [15:0] reload_q;
	logic [15:0] count_q;
	logic        armed_q;
	logic [1:0]  mirror_q;

	// input register
	logic        valid_s1;
	logic        kind_s1;
	logic [15:0] address_s1;
	logic [3:0]  nib_s1;

	// result register
	logic        valid_s2;
	logic        changed_s2;
	logic [3:0]  index_s2;
	logic [7:0]  bank_s2;
	logic [7:0]  fixed_s2;
	logic [1:0]  mirror_s2;
	logic        irq_s2;

	logic advance;

	assign advance    = valid_s1 && (!valid_s2 || result_ready);
	assign item_ready = !valid_s1 || advance;

	// slot decode and nibble merge
	logic [3:0] page;
	logic       low_ok;
	logic       slot_hit;
	logic [3:0] slot_sel;
	logic [1:0] chr_pair;
	logic [7:0] slot_cur;
	logic [7:0] slot_new;
	logic       is_write;
	logic       is_tick;
	logic       irq_fire;

	assign page     = address_s1[15:12];
	assign low_ok   = (address_s1[11:2] == 10'd0);
	assign chr_pair = 2'(page[2:0] - PAGE_CHR_A[2:0]);
	assign is_write = (kind_s1 == KIND_WRITE);
	assign is_tick  = (kind_s1 == KIND_TICK);
	assign irq_fire = is_tick && armed_q && (count_q <= LINE_STEP);

	always_comb begin
		slot_hit = 1'b0;
		slot_sel = 4'd0;
		case (page)
			PAGE_PRG01: begin
				slot_hit = low_ok;
				slot_sel = {3'd0, address_s1[1]};
			end
			PAGE_PRG2: begin
				slot_hit = low_ok && !address_s1[1];
				slot_sel = SLOT_PRG2;
			end
			PAGE_CHR_A, PAGE_CHR_B, PAGE_CHR_C, PAGE_CHR_D: begin
				slot_hit = low_ok;
				slot_sel = SLOT_CHR_BASE + {1'b0, chr_pair, address_s1[1]};
			end
			default: begin
				slot_hit = 1'b0;
				slot_sel = 4'd0;
			end
		endcase
		slot_hit = slot_hit && is_write;
	end

	always_comb begin
		slot_cur = 8'd0;
		for (int i = 0; i < SLOT_COUNT; i++) begin
			if (slot_sel == 4'(i)) begin
				slot_cur = bank_q[i];
			end
		end
		if (address_s1[0]) begin
			slot_new = {nib_s1, slot_cur[3:0]};
		end else begin
			slot_new = {slot_cur[7:4], nib_s1};
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_ready && item_valid) begin
			kind_s1    <= kind;
			address_s1 <= address;
			nib_s1     <= value[3:0];
		end
	end

	// configuration and mapper state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prg_count_q <= PRG_COUNT_RESET;
			patch_q     <= 1'b0;
			for (int i = 0; i < SLOT_COUNT; i++) begin
				if (i == 1) begin
					bank_q[i] <= 8'd1;
				end else if (i == int'(SLOT_PRG2)) begin
					bank_q[i] <= 8'(PRG_COUNT_RESET - 9'd2);
				end else begin
					bank_q[i] <= 8'd0;
				end
			end
			reload_q    <= 16'd0;
			count_q     <= 16'd0;
			armed_q     <= 1'b0;
			mirror_q    <= MIRROR_HORIZ;
		end else begin
			if (advance) begin
				if (is_tick) begin
					if (irq_fire) begin
						count_q <= patch_q ? PATCH_RELOAD : 16'd0;
						armed_q <= 1'b0;
					end else if (armed_q) begin
						count_q <= count_q - LINE_STEP;
					end
				end else if (slot_hit) begin
					bank_q[slot_sel] <= slot_new;
				end else begin
					case (address_s1)
						ADDR_RELOAD0: reload_q[3:0]   <= nib_s1;
						ADDR_RELOAD1: reload_q[7:4]   <= nib_s1;
						ADDR_RELOAD2: reload_q[11:8]  <= nib_s1;
						ADDR_RELOAD3: reload_q[15:12] <= nib_s1;
						ADDR_LOAD:    count_q         <= reload_q;
						ADDR_ENABLE:  armed_q         <= nib_s1[0];
						ADDR_MIRROR: begin
							if (nib_s1[1]) begin
								mirror_q <= MIRROR_SINGLE;
							end else begin
								mirror_q <= nib_s1[0] ? MIRROR_VERT : MIRROR_HORIZ;
							end
						end
						default: begin
						end
					endcase
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					CFG_PRG_BANK_COUNT: begin
						prg_count_q       <= cfg_data;
						bank_q[SLOT_PRG2] <= 8'(cfg_data - 9'd2);
					end
					CFG_PATCH_MODE: patch_q <= cfg_data[0];
					default: begin
					end
				endcase
			end
		end
	end

	// the mirroring reported is the mode after this item
	logic [1:0] mirror_next;

	always_comb begin
		mirror_next = mirror_q;
		if (is_write && !slot_hit && address_s1 == ADDR_MIRROR) begin
			if (nib_s1[1]) begin
				mirror_next = MIRROR_SINGLE;
			end else begin
				mirror_next = nib_s1[0] ? MIRROR_VERT : MIRROR_HORIZ;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (result_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			changed_s2 <= slot_hit;
			index_s2   <= slot_hit ? slot_sel : 4'd0;
			bank_s2    <= slot_hit ? slot_new : 8'd0;
			fixed_s2   <= 8'(prg_count_q - 9'd1);
			mirror_s2  <= mirror_next;
			irq_s2     <= irq_fire;
		end
	end

	assign result_valid = valid_s2;
	assign slot_changed = changed_s2;
	assign slot_index   = index_s2;
	assign slot_bank    = bank_s2;
	assign fixed_bank   = fixed_s2;
	assign mirroring    = mirror_s2;
	assign irq_request  = irq_s2;

`include "nibble_bank_switch_with_irq_timer_assert.svh"

	`NBS_ASSERT_IMPL(a_irq_not_slot, clk, arst_n, result_valid, !(irq_request && slot_changed))
	`NBS_ASSERT_IMPL(a_slot_range, clk, arst_n, result_valid && slot_changed, slot_index <= 4'd10)
	`NBS_ASSERT_IMPL(a_no_slot_zero, clk, arst_n, result_valid && !slot_changed, (slot_index == 4'd0) && (slot_bank == 8'd0))
	`NBS_ASSERT_NEXT(a_irq_disarms, clk, arst_n, advance && irq_fire && !cfg_we, !armed_q)
	`NBS_ASSERT_IMPL(a_mirror_code, clk, arst_n, 1'b1, mirror_q != 2'd3)

endmodule

`default_nettype wire

// ===== tb/sv/nibble_bank_switch_with_irq_timer_test.sv =====
// ----------------------------------------------------------------------------
// Bank-switch controller testbench
// Drives CPU writes and scanline ticks through the item channel. A shadow copy
// of the bank slots, IRQ latch/counter and mirroring predicts each unpinned
// result; each result is checked field by field in order. Runs a directed table
// first, then random write/IRQ sequences under several bank-count/patch settings.
// ----------------------------------------------------------------------------
module nibble_bank_switch_with_irq_timer_test;
	import nbsirq_pkg::*;

	localparam int unsigned PHASE_ITEMS = 170;
	localparam int unsigned CYCLE_LIMIT = 800000;
	localparam int unsigned ROW_COUNT   = 26;

	typedef struct packed {
		logic       changed;
		logic [3:0] index;
		logic [7:0] bank;
		logic [7:0] fixed;
		logic [1:0] mirror;
		logic       irq;
	} outcome_t;

	typedef struct packed {
		logic        k;
		logic [15:0] addr;
		logic [7:0]  val;
		logic        pinned;
		outcome_t    want;
	} row_t;

	// nothing mapped, default bank count, horizontal
	localparam outcome_t QUIET_OUT = '{1'b0, 4'd0, 8'd0, 8'h0F, MIRROR_HORIZ, 1'b0};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic cfg_index = CFG_PRG_BANK_COUNT;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic item_valid = 1'b0;
	logic item_ready;
	logic kind = KIND_WRITE;
	logic [15:0] address = '0;
	logic [7:0] value = '0;
	logic result_valid;
	logic result_ready = 1'b0;
	logic slot_changed;
	logic [3:0] slot_index;
	logic [7:0] slot_bank;
	logic [7:0] fixed_bank;
	logic [1:0] mirroring;
	logic irq_request;

	// shadow state
	logic [7:0]  shadow_bank [SLOT_COUNT];
	logic [15:0] shadow_reload;
	logic [15:0] shadow_count;
	logic        shadow_armed;
	logic [1:0]  shadow_mirror;
	logic [8:0]  shadow_prg_count;
	logic        shadow_patch;

	outcome_t results_q [$];
	row_t pin_q [$];
	row_t directed_rows [ROW_COUNT];
	bit failed = 1'b0;
	bit hurry = 1'b0;
	int unsigned cycle_count = 0;

	nibble_bank_switch_with_irq_timer i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.kind(kind),
		.address(address),
		.value(value),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.slot_changed(slot_changed),
		.slot_index(slot_index),
		.slot_bank(slot_bank),
		.fixed_bank(fixed_bank),
		.mirroring(mirroring),
		.irq_request(irq_request)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	function automatic void shadow_reset();
		shadow_prg_count = PRG_COUNT_RESET;
		shadow_patch = 1'b0;
		foreach (shadow_bank[i])
			shadow_bank[i] = 8'd0;
		shadow_bank[1] = 8'd1;
		shadow_bank[SLOT_PRG2] = shadow_prg_count[7:0] - 8'd2;
		shadow_reload = '0;
		shadow_count = '0;
		shadow_armed = 1'b0;
		shadow_mirror = MIRROR_HORIZ;
	endfunction

	// Applies one item to the shadow state and returns the result it yields.
	function automatic outcome_t bank_map_outcome(input logic k, input logic [15:0] addr,
			input logic [7:0] val);
		outcome_t o;
		logic [3:0] nib;
		logic [3:0] page;
		int slot;
		o = '0;
		nib = val[3:0];
		page = addr[15:12];
		slot = -1;
		if (k == KIND_TICK) begin
			if (shadow_armed) begin
				if (shadow_count <= LINE_CYCLES_DEF) begin
					o.irq = 1'b1;
					shadow_count = shadow_patch ? PATCH_RELOAD : 16'd0;
					shadow_armed = 1'b0;
				end else
					shadow_count = shadow_count - 16'(LINE_CYCLES_DEF);
			end
		end else begin
			// slots sit at offsets 0-3 of their page only; 9002/9003 are holes
			if (addr[11:2] == '0) begin
				if (page == PAGE_PRG01)
					slot = int'(addr[1]);
				else if (page == PAGE_PRG2 && !addr[1])
					slot = int'(SLOT_PRG2);
				else if (page >= PAGE_CHR_A && page <= PAGE_CHR_D)
					slot = int'(SLOT_CHR_BASE) + 2 * int'(page - PAGE_CHR_A) + int'(addr[1]);
			end
			if (slot >= 0) begin
				if (addr[0])
					shadow_bank[slot][7:4] = nib;
				else
					shadow_bank[slot][3:0] = nib;
				o.changed = 1'b1;
				o.index = slot[3:0];
				o.bank = shadow_bank[slot];
			end else begin
				case (addr)
					ADDR_RELOAD0: shadow_reload[3:0] = nib;
					ADDR_RELOAD1: shadow_reload[7:4] = nib;
					ADDR_RELOAD2: shadow_reload[11:8] = nib;
					ADDR_RELOAD3: shadow_reload[15:12] = nib;
					ADDR_LOAD:    shadow_count = shadow_reload;
					ADDR_ENABLE:  shadow_armed = nib[0];
					ADDR_MIRROR:  shadow_mirror = nib[1] ? MIRROR_SINGLE :
						(nib[0] ? MIRROR_VERT : MIRROR_HORIZ);
					default: ;
				endcase
			end
		end
		o.fixed = shadow_prg_count[7:0] - 8'd1;
		o.mirror = shadow_mirror;
		return o;
	endfunction

	always @(posedge clk) begin
		outcome_t predicted;
		outcome_t want;
		row_t note;
		if (arst_n) begin
			if (item_valid && item_ready) begin
				predicted = bank_map_outcome(kind, address, value);
				note = pin_q.pop_front();
				results_q.push_back(note.pinned ? note.want : predicted);
			end
			if (result_valid && result_ready) begin
				if (results_q.size() == 0) begin
					$error("result with no item outstanding");
					failed = 1'b1;
				end else begin
					want = results_q.pop_front();
					if (slot_changed !== want.changed) begin
						$error("slot_changed: expected %0d, got %0d", want.changed, slot_changed);
						failed = 1'b1;
					end
					if (slot_index !== want.index) begin
						$error("slot_index: expected %0d, got %0d", want.index, slot_index);
						failed = 1'b1;
					end
					if (slot_bank !== want.bank) begin
						$error("slot_bank: expected %0h, got %0h", want.bank, slot_bank);
						failed = 1'b1;
					end
					if (fixed_bank !== want.fixed) begin
						$error("fixed_bank: expected %0h, got %0h", want.fixed, fixed_bank);
						failed = 1'b1;
					end
					if (mirroring !== want.mirror) begin
						$error("mirroring: expected %0d, got %0d", want.mirror, mirroring);
						failed = 1'b1;
					end
					if (irq_request !== want.irq) begin
						$error("irq_request: expected %0d, got %0d", want.irq, irq_request);
						failed = 1'b1;
					end
				end
			end
		end
	end

	function automatic int unsigned pick_idle();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// result side: runs of ready with random stalls, now and then a long clean run
	initial begin
		while (!arst_n)
			@(posedge clk);
		forever begin
			result_ready <= 1'b1;
			repeat (($urandom_range(0, 9) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 20))
				@(posedge clk);
			result_ready <= 1'b0;
			repeat (pick_idle() + 1)
				@(posedge clk);
		end
	end

	// Returns at the edge where the item was taken; valid is left high.
	task automatic send_item(input logic k, input logic [15:0] addr, input logic [7:0] val,
			input logic pinned, input outcome_t want);
		row_t note;
		int unsigned idle;
		idle = hurry ? 0 : pick_idle();
		note = '{k, addr, val, pinned, want};
		pin_q.push_back(note);
		if (idle != 0) begin
			item_valid <= 1'b0;
			repeat (idle)
				@(posedge clk);
		end
		item_valid <= 1'b1;
		kind <= k;
		address <= addr;
		value <= val;
		do
			@(posedge clk);
		while (!item_ready);
	endtask

	task automatic send_write(input logic [15:0] addr, input logic [7:0] val);
		send_item(KIND_WRITE, addr, val, 1'b0, '0);
	endtask

	task automatic send_tick();
		send_item(KIND_TICK, 16'($urandom), 8'($urandom), 1'b0, '0);
	endtask

	function automatic logic [15:0] slot_address();
		logic [3:0] page;
		logic [1:0] low;
		page = PAGE_PRG01 + 4'($urandom_range(0, 5));
		low = 2'($urandom_range(0, 3));
		return {page, 10'd0, low};
	endfunction

	// Load latch, copy, arm, then tick until it should fire; sometimes broken up.
	task automatic irq_sequence(output int unsigned sent);
		logic [15:0] span;
		logic [15:0] reload_addr [4];
		int unsigned r;
		int unsigned ticks;
		reload_addr = '{ADDR_RELOAD0, ADDR_RELOAD1, ADDR_RELOAD2, ADDR_RELOAD3};
		sent = 0;
		r = $urandom_range(0, 99);
		if (r < 45)
			span = 16'($urandom_range(0, 400));
		else if (r < 70) begin
			case ($urandom_range(0, 8))
				0: span = 16'd0;
				1: span = 16'd1;
				2: span = 16'd112;
				3: span = 16'd113;
				4: span = 16'd114;
				5: span = 16'd226;
				6: span = 16'd227;
				7: span = 16'd228;
				default: span = 16'hFFFF;
			endcase
		end else if (r < 90)
			span = 16'($urandom_range(0, 3000));
		else
			span = 16'($urandom);
		for (int n = 0; n < 4; n++) begin
			if ($urandom_range(0, 19) != 0) begin
				send_write(reload_addr[n], {4'($urandom), span[4 * n +: 4]});
				sent++;
			end
		end
		if ($urandom_range(0, 9) == 0) begin
			send_write(ADDR_ENABLE, {7'($urandom), 1'b1});
			send_write(ADDR_LOAD, 8'($urandom));
		end else begin
			send_write(ADDR_LOAD, 8'($urandom));
			send_write(ADDR_ENABLE, {7'($urandom), 1'b1});
		end
		sent += 2;
		ticks = int'(span) / LINE_CYCLES_DEF + 2;
		if (ticks > 30)
			ticks = 30;
		for (int n = 0; n < ticks; n++) begin
			if ($urandom_range(0, 4) == 0) begin
				send_write(slot_address(), 8'($urandom));
				sent++;
			end
			if ($urandom_range(0, 39) == 0) begin
				send_write(ADDR_ENABLE, {7'($urandom), 1'b0});
				sent++;
			end
			send_tick();
			sent++;
		end
		// re-arm without a reload: counter runs from what the IRQ left behind
		if ($urandom_range(0, 3) == 0) begin
			send_write(ADDR_ENABLE, {7'($urandom), 1'b1});
			repeat (3)
				send_tick();
			sent += 4;
		end
	endtask

	task automatic random_stretch(input int unsigned target);
		int unsigned done;
		int unsigned pick;
		int unsigned sent;
		done = 0;
		while (done < target) begin
			hurry = ($urandom_range(0, 7) == 0);
			pick = $urandom_range(0, 99);
			if (pick < 40) begin
				send_write(slot_address(), 8'($urandom));
				done++;
			end else if (pick < 65) begin
				irq_sequence(sent);
				done += sent;
			end else if (pick < 75) begin
				send_write(ADDR_MIRROR, 8'($urandom));
				done++;
			end else if (pick < 85) begin
				repeat ($urandom_range(1, 3)) begin
					send_tick();
					done++;
				end
			end else if (pick < 95) begin
				// noise: anywhere in the address space, either kind
				send_item(1'($urandom), 16'($urandom), 8'($urandom), 1'b0, '0);
				done++;
			end else begin
				case ($urandom_range(0, 6))
					0: send_write(ADDR_RELOAD0, 8'($urandom));
					1: send_write(ADDR_RELOAD1, 8'($urandom));
					2: send_write(ADDR_RELOAD2, 8'($urandom));
					3: send_write(ADDR_RELOAD3, 8'($urandom));
					4: send_write(ADDR_LOAD, 8'($urandom));
					5: send_write(ADDR_ENABLE, 8'($urandom));
					default: send_write(ADDR_MIRROR, 8'($urandom));
				endcase
				done++;
			end
		end
		hurry = 1'b0;
	endtask

	// drop valid and let every outstanding result drain; the first edge lets
	// the monitor log the item taken at the edge we were called on
	task automatic settle();
		item_valid <= 1'b0;
		@(posedge clk);
		while (results_q.size() != 0)
			@(posedge clk);
		repeat (4)
			@(posedge clk);
	endtask

	task automatic program_registers(input logic [8:0] count, input logic patch);
		cfg_we <= 1'b1;
		cfg_index <= CFG_PRG_BANK_COUNT;
		cfg_data <= count;
		@(posedge clk);
		cfg_index <= CFG_PATCH_MODE;
		cfg_data <= {{(CFG_DATA_W - 1){1'b0}}, patch};
		@(posedge clk);
		cfg_we <= 1'b0;
		shadow_prg_count = count;
		shadow_bank[SLOT_PRG2] = count[7:0] - 8'd2;
		shadow_patch = patch;
	endtask

	initial begin
		shadow_reset();
		directed_rows = '{
			'{KIND_TICK,  16'hFFFF, 8'hFF, 1'b1, QUIET_OUT},
			'{KIND_WRITE, 16'h8000, 8'hFF, 1'b1, '{1'b1, 4'd0, 8'h0F, 8'h0F, MIRROR_HORIZ, 1'b0}},
			'{KIND_WRITE, 16'h8001, 8'hA5, 1'b1, '{1'b1, 4'd0, 8'h5F, 8'h0F, MIRROR_HORIZ, 1'b0}},
			'{KIND_WRITE, 16'h8002, 8'h03, 1'b1, '{1'b1, 4'd1, 8'h03, 8'h0F, MIRROR_HORIZ, 1'b0}},
			'{KIND_WRITE, 16'h9000, 8'h07, 1'b1, '{1'b1, 4'd2, 8'h07, 8'h0F, MIRROR_HORIZ, 1'b0}},
			'{KIND_WRITE, 16'h9001, 8'hF0, 1'b0, '0},
			'{KIND_WRITE, 16'h9002, 8'hFF, 1'b1, QUIET_OUT},
			'{KIND_WRITE, 16'h9003, 8'hFF, 1'b1, QUIET_OUT},
			'{KIND_WRITE, 16'hA000, 8'h09, 1'b0, '0},
			'{KIND_WRITE, 16'hB001, 8'h6E, 1'b0, '0},
			'{KIND_WRITE, 16'hD003, 8'hFF, 1'b1, '{1'b1, 4'd10, 8'hF0, 8'h0F, MIRROR_HORIZ, 1'b0}},
			'{KIND_WRITE, 16'h8004, 8'hFF, 1'b1, QUIET_OUT},
			'{KIND_WRITE, 16'h0000, 8'h00, 1'b1, QUIET_OUT},
			'{KIND_WRITE, ADDR_MIRROR, 8'h01, 1'b1, '{1'b0, 4'd0, 8'd0, 8'h0F, MIRROR_VERT, 1'b0}},
			'{KIND_WRITE, ADDR_MIRROR, 8'h03, 1'b1, '{1'b0, 4'd0, 8'd0, 8'h0F, MIRROR_SINGLE, 1'b0}},
			'{KIND_WRITE, ADDR_MIRROR, 8'h00, 1'b0, '0},
			'{KIND_WRITE, ADDR_RELOAD0, 8'h0E, 1'b0, '0},
			'{KIND_WRITE, ADDR_RELOAD1, 8'h0E, 1'b0, '0},
			'{KIND_WRITE, ADDR_RELOAD2, 8'hF0, 1'b0, '0},
			'{KIND_WRITE, ADDR_RELOAD3, 8'hF0, 1'b0, '0},
			'{KIND_WRITE, ADDR_LOAD, 8'h00, 1'b0, '0},
			'{KIND_WRITE, ADDR_ENABLE, 8'hFF, 1'b0, '0},
			'{KIND_TICK,  16'h0000, 8'h00, 1'b0, '0},
			'{KIND_TICK,  16'h1234, 8'h55, 1'b0, '0},
			'{KIND_TICK,  16'hFFFF, 8'hFF, 1'b1, '{1'b0, 4'd0, 8'd0, 8'h0F, MIRROR_HORIZ, 1'b1}},
			'{KIND_TICK,  16'h0000, 8'h00, 1'b1, QUIET_OUT}
		};
		repeat (5)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i])
			send_item(directed_rows[i].k, directed_rows[i].addr, directed_rows[i].val,
				directed_rows[i].pinned, directed_rows[i].want);
		random_stretch(PHASE_ITEMS);

		for (int phase = 1; phase <= 6; phase++) begin
			settle();
			case (phase)
				1: program_registers(9'd2, 1'b1);
				2: program_registers(9'd256, 1'b0);
				3: program_registers(9'd0, 1'b1);
				4: program_registers(9'd1, 1'b0);
				5: program_registers(9'd511, 1'b1);
				default: program_registers(9'($urandom_range(2, 256)), 1'($urandom));
			endcase
			random_stretch(PHASE_ITEMS);
		end
		settle();

		if (!failed)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
